// ----- hdl/kdef_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kdef_pkg;

    // Fixed widths of the item fields
    localparam int PIN_COUNT   = 4;
    localparam int CODE_W      = 2;
    localparam int COUNT_W     = 5;
    localparam int DELAY_W     = 16;
    localparam int CFG_INDEX_W = 2;

    // Storage banks: one per possible push in a single tick
    localparam int BANKS       = PIN_COUNT;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_DELAY  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_DELAY = 2'd1;

    // Item operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [DELAY_W-1:0] FIRST_DELAY_RST  = 16'd1;
    localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = 16'd10;

    typedef struct packed {
        logic                 operation;
        logic [PIN_COUNT-1:0] key_pins;
    } t_req;

    typedef struct packed {
        logic               read_valid;
        logic [CODE_W-1:0]  key_code;
        logic [COUNT_W-1:0] fifo_count;
        logic               overflow;
    } t_rsp;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [DELAY_W-1:0]     wr_data;
    } t_cfg;

    typedef struct packed {
        logic [DELAY_W-1:0] first_delay;
        logic [DELAY_W-1:0] repeat_delay;
    } t_delay_cfg;

    typedef struct packed {
        logic item;   // any request accepted
        logic read;   // accepted request is a read
    } t_fifo_ctl;

endpackage

`default_nettype wire

// ----- hdl/kdef_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface kdef_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/kdef_key_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kdef_key_lane (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_tick,
    input  wire logic                  i_pin_low,
    input  wire kdef_pkg::t_delay_cfg  i_delay,
    output logic                       o_push
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PENDING,
        ST_HELD
    } t_key_state;

    t_key_state                         r_state, n_state;
    logic [kdef_pkg::DELAY_W-1:0]       r_count, n_count;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        o_push  = 1'b0;
        if (i_tick) begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_pin_low) begin
                        n_state = ST_PENDING;
                        n_count = i_delay.first_delay;
                    end
                end
                default: begin
                    // count down; sample the pin once the timer runs out
                    if (r_count > kdef_pkg::DELAY_W'(1)) begin
                        n_count = r_count - kdef_pkg::DELAY_W'(1);
                    end else if (i_pin_low) begin
                        if (r_state == ST_PENDING) begin
                            n_state = ST_HELD;
                            o_push  = 1'b1;
                        end
                        n_count = i_delay.repeat_delay;
                    end else begin
                        n_state = ST_IDLE;
                        n_count = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/kdef_event_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kdef_event_fifo #(
    parameter int FIFO_DEPTH = 16,
    parameter int LANES      = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire kdef_pkg::t_fifo_ctl i_ctl,
    input  wire logic [LANES-1:0]    i_push,
    output kdef_pkg::t_rsp           o_stat
);

    localparam int BANKS = kdef_pkg::BANKS;
    localparam int ROWS  = (FIFO_DEPTH + BANKS - 1) / BANKS;
    localparam int RING  = ROWS * BANKS;
    localparam int PW    = $clog2(RING);
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = $clog2(FIFO_DEPTH + 1);

    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_pop_valid;
    logic [1:0]    r_rd_bank;

    logic                         pop;
    logic [2:0]                   rank;
    logic [PW:0]                  slot_sum;
    logic [PW-1:0]                slot;
    logic [PW:0]                  wr_sum;
    logic [PW:0]                  rd_sum;
    logic [BANKS-1:0]             bank_we;
    logic [RW-1:0]                bank_row  [BANKS];
    logic [kdef_pkg::CODE_W-1:0]  bank_code [BANKS];
    logic [kdef_pkg::CODE_W-1:0]  bank_q    [BANKS];
    logic [RW-1:0]                rd_row;

    assign pop    = i_ctl.read && (r_count != '0);
    assign rd_row = RW'(r_rd >> 2);

    // Merge: give each accepted push the next slot, lower lanes first
    always_comb begin
        rank    = '0;
        n_ovf   = r_ovf;
        bank_we = '0;
        slot_sum = '0;
        slot    = '0;
        for (int b = 0; b < BANKS; b++) begin
            bank_row[b]  = '0;
            bank_code[b] = '0;
        end
        for (int i = 0; i < LANES; i++) begin
            if (i_push[i]) begin
                if ((CW+1)'(r_count) + (CW+1)'(rank) < (CW+1)'(FIFO_DEPTH)) begin
                    slot_sum = (PW+1)'(r_wr) + (PW+1)'(rank);
                    if (slot_sum >= (PW+1)'(RING)) begin
                        slot_sum = slot_sum - (PW+1)'(RING);
                    end
                    slot = slot_sum[PW-1:0];
                    bank_we[slot[1:0]]   = 1'b1;
                    bank_row[slot[1:0]]  = RW'(slot >> 2);
                    bank_code[slot[1:0]] = kdef_pkg::CODE_W'(i);
                    rank = rank + 3'd1;
                end else begin
                    n_ovf = 1'b1;
                end
            end
        end
    end

    always_comb begin
        wr_sum = (PW+1)'(r_wr) + (PW+1)'(rank);
        if (wr_sum >= (PW+1)'(RING)) begin
            wr_sum = wr_sum - (PW+1)'(RING);
        end
        n_wr = wr_sum[PW-1:0];

        rd_sum = (PW+1)'(r_rd) + (PW+1)'(pop);
        if (rd_sum >= (PW+1)'(RING)) begin
            rd_sum = '0;
        end
        n_rd = rd_sum[PW-1:0];

        n_count = r_count + CW'(rank) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_pop_valid <= 1'b0;
        end else if (i_ctl.item) begin
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_pop_valid <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rd_bank <= r_rd[1:0];
        end
    end

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [kdef_pkg::CODE_W-1:0] r_mem [ROWS];
        logic [kdef_pkg::CODE_W-1:0] r_q;

        always_ff @(posedge i_clk) begin
            if (bank_we[b]) begin
                r_mem[bank_row[b]] <= bank_code[b];
            end
            if (pop) begin
                r_q <= r_mem[rd_row];
            end
        end

        assign bank_q[b] = r_q;
    end

    assign o_stat.read_valid = r_pop_valid;
    assign o_stat.key_code   = r_pop_valid ? bank_q[r_rd_bank] : '0;
    assign o_stat.fifo_count = kdef_pkg::COUNT_W'(r_count);
    assign o_stat.overflow   = r_ovf;

endmodule

`default_nettype wire

// ----- hdl/key_debounce_event_fifo_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                      Handshake
// i_req     in   operation, key_pins                          valid / ready
// o_rsp     out  read_valid, key_code, fifo_count, overflow   valid / ready
// i_cfg     in   reg_index, wr_data                           valid / ready (always ready)
//
// One request per clock unless o_rsp stalls; its response shows the cycle after.
// The per-key lanes and the combinational slot merge set this: every tick
// updates all keys and writes up to four codes into four storage banks at once.
// Reset is synchronous and needs no clearing pass; stored codes are only read
// after they were written. The response sits in an output register, and a new
// request is taken whenever that register is empty or being drained.

module key_debounce_event_fifo_core #(
    parameter int KEYS       = 4,
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    kdef_stream_if.sink       i_req,
    kdef_stream_if.source     o_rsp,
    kdef_stream_if.sink       i_cfg
);

    // Only keys with a pin can ever push
    localparam int LANES = (KEYS < kdef_pkg::PIN_COUNT) ? KEYS : kdef_pkg::PIN_COUNT;

    logic                    r_out_valid;
    kdef_pkg::t_delay_cfg    r_delay;
    logic                    req_accept;
    logic                    cfg_accept;
    logic                    tick;
    logic [KEYS-1:0]         push;
    kdef_pkg::t_fifo_ctl     fifo_ctl;
    kdef_pkg::t_rsp          fifo_stat;

    // Take a request while the response register is empty or being taken
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign req_accept  = i_req.valid && i_req.ready;
    assign tick        = req_accept && (i_req.data.operation == kdef_pkg::OP_TICK);

    assign fifo_ctl.item = req_accept;
    assign fifo_ctl.read = req_accept && (i_req.data.operation == kdef_pkg::OP_READ);

    // Configuration writes land at once
    assign i_cfg.ready = 1'b1;
    assign cfg_accept  = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay.first_delay  <= kdef_pkg::FIRST_DELAY_RST;
            r_delay.repeat_delay <= kdef_pkg::REPEAT_DELAY_RST;
        end else if (cfg_accept) begin
            unique case (i_cfg.data.reg_index)
                kdef_pkg::CFG_FIRST_DELAY:  r_delay.first_delay  <= i_cfg.data.wr_data;
                kdef_pkg::CFG_REPEAT_DELAY: r_delay.repeat_delay <= i_cfg.data.wr_data;
                default: ; // drop writes to unknown registers
            endcase
        end
    end

    // One debounce lane per key; pins are active low
    for (genvar k = 0; k < KEYS; k++) begin : g_lane
        logic pin_low;

        if (k < kdef_pkg::PIN_COUNT) begin : g_pin
            assign pin_low = ~i_req.data.key_pins[k];
        end else begin : g_no_pin
            assign pin_low = 1'b0;
        end

        kdef_key_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tick    (tick),
            .i_pin_low (pin_low),
            .i_delay   (r_delay),
            .o_push    (push[k])
        );
    end

    // Merge lane pushes into the event store; its registers form the response
    kdef_event_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .LANES      (LANES)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fifo_ctl),
        .i_push  (push[LANES-1:0]),
        .o_stat  (fifo_stat)
    );

    // Hold the response until taken; set on every accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = fifo_stat;

    // Overflow never clears outside reset
    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.data.overflow |=> o_rsp.data.overflow)
        else $error("overflow flag cleared");

    // A tick never returns a code
    a_tick_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_accept && (i_req.data.operation == kdef_pkg::OP_TICK))
            |=> !o_rsp.data.read_valid)
        else $error("tick returned a key code");

    // Key code is zero unless a code was popped
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.data.read_valid) |-> (o_rsp.data.key_code == '0))
        else $error("key code set without a read");

    // Store occupancy moves only with an accepted request
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !req_accept |=> $stable(o_rsp.data.fifo_count))
        else $error("fifo count changed without a request");

endmodule

`default_nettype wire
